>>> rtl/core/imsf_pkg.sv
// Shared types and constants of the Ising Metropolis spin-flip engine.
package imsf_pkg;

    localparam int ACTION_W    = 2;
    localparam int INDEX_W     = 6;
    localparam int COUPLING_W  = 16;
    localparam int RANDOM_W    = 16;
    localparam int BETA_W      = 16;
    localparam int SPIN_CNT_W  = 7;
    localparam int ENERGY_W    = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [BETA_W-1:0]     BETA_RESET       = 16'd4096;
    localparam logic [SPIN_CNT_W-1:0] SPIN_COUNT_RESET = 7'd64;

    localparam logic [CFG_INDEX_W-1:0] CFG_BETA       = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPIN_COUNT = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WR_COUPLING = 2'd0,
        ACT_WR_SPIN     = 2'd1,
        ACT_FLIP        = 2'd2,
        ACT_REPORT      = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PIV,
        S_PLAT,
        S_WALK,
        S_DRAIN,
        S_DE,
        S_MUL,
        S_IDX,
        S_LUT,
        S_ESAT,
        S_RES
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic wr_store;
        logic pivot_rd;
        logic pivot_lat;
        logic walk_issue;
        logic row_next;
        logic calc_de;
        logic calc_mul;
        logic calc_idx;
        logic decide;
        logic calc_energy;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action action;
        logic    flip_ok;
        logic    n_zero;
        logic    walk_last;
        logic    row_last;
    } t_sts;

endpackage

>>> rtl/core/imsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/imsf_ctrl.sv
// Sequencer for the Metropolis engine: item dispatch, walks and result hand-off.
module imsf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  imsf_pkg::t_sts i_sts,
    output imsf_pkg::t_cmd o_cmd
);
    import imsf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load_item = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.action)
                    ACT_WR_COUPLING, ACT_WR_SPIN: begin
                        cmd.wr_store = 1'b1;
                        n_state = S_RES;
                    end
                    ACT_FLIP: n_state = i_sts.flip_ok ? S_PIV : S_RES;
                    default:  n_state = i_sts.n_zero ? S_ESAT : S_PIV;
                endcase
            end
            S_PIV: begin
                cmd.pivot_rd = 1'b1;
                n_state = S_PLAT;
            end
            S_PLAT: begin
                cmd.pivot_lat = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                cmd.walk_issue = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.action == ACT_FLIP) begin
                    n_state = S_DE;
                end else if (i_sts.row_last) begin
                    n_state = S_ESAT;
                end else begin
                    cmd.row_next = 1'b1;
                    n_state = S_PIV;
                end
            end
            S_DE: begin
                cmd.calc_de = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                cmd.calc_mul = 1'b1;
                n_state = S_IDX;
            end
            S_IDX: begin
                cmd.calc_idx = 1'b1;
                n_state = S_LUT;
            end
            S_LUT: begin
                cmd.decide = 1'b1;
                n_state = S_RES;
            end
            S_ESAT: begin
                cmd.calc_energy = 1'b1;
                n_state = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || !i_stall) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || !i_stall))
        else $error("result overwritten while still waiting");
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DISPATCH))
        else $error("accepted request not dispatched");
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_item, cmd.wr_store, cmd.pivot_rd, cmd.walk_issue,
                  cmd.calc_de, cmd.decide, cmd.calc_energy}))
        else $error("conflicting datapath commands");

endmodule

>>> rtl/core/imsf_datapath.sv
// Datapath: stores, walk accumulator, acceptance test and result registers.
module imsf_datapath #(
    parameter int MAX_SPINS       = 64,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [imsf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [imsf_pkg::BETA_W-1:0]         i_cfg_data,
    input  logic [imsf_pkg::ACTION_W-1:0]       i_action,
    input  logic [imsf_pkg::INDEX_W-1:0]        i_row,
    input  logic [imsf_pkg::INDEX_W-1:0]        i_col,
    input  logic signed [imsf_pkg::COUPLING_W-1:0] i_coupling,
    input  logic [imsf_pkg::INDEX_W-1:0]        i_spin_index,
    input  logic                                i_spin_up,
    input  logic [imsf_pkg::RANDOM_W-1:0]       i_random_uniform,
    input  imsf_pkg::t_cmd                      i_cmd,
    output imsf_pkg::t_sts                      o_sts,
    output logic                                o_accepted,
    output logic signed [imsf_pkg::ENERGY_W-1:0] o_delta_energy,
    output logic signed [imsf_pkg::ENERGY_W-1:0] o_energy
);
    import imsf_pkg::*;

    localparam int IW   = $clog2(MAX_SPINS);
    localparam int NW   = $clog2(MAX_SPINS + 1);
    localparam int CAW  = $clog2(MAX_SPINS * MAX_SPINS);
    localparam int AW   = CAW + COUPLING_W + 2;
    localparam int TIW  = $clog2(EXP_TABLE_DEPTH);
    localparam int PW   = 31 + TIW;
    localparam int XW   = 31 + BETA_W;
    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    typedef logic [16:0] t_exp_tab [EXP_TABLE_DEPTH];

    // exp(-f), f and result in Q32
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        logic [63:0] s;
        logic [63:0] t;
        s = 64'h1_0000_0000;
        t = 64'h1_0000_0000;
        for (int i = 1; i <= 24; i++) begin
            t = ((t * f) >> 32) / 64'(i);
            if (i[0]) s = s - t;
            else      s = s + t;
        end
        return s;
    endfunction

    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    tab;
        logic [63:0] half;
        logic [63:0] einv;
        logic [63:0] y;
        logic [63:0] v;
        half = exp_neg_frac(64'h8000_0000);
        einv = (half * half) >> 32;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            y = ((64'(k) * 64'd16) << 32) / 64'(EXP_TABLE_DEPTH);
            v = exp_neg_frac(y & 64'hFFFF_FFFF);
            for (int m = 0; m < int'(y >> 32); m++) begin
                v = (v * einv) >> 32;
            end
            tab[k] = 17'((v + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

    function automatic logic signed [ENERGY_W-1:0] sat32(input logic signed [AW:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > SAT_MAX)      return ENERGY_W'(SAT_MAX);
        else if (w < SAT_MIN) return ENERGY_W'(SAT_MIN);
        else                  return ENERGY_W'(w);
    endfunction

    // configuration
    logic [BETA_W-1:0]     r_beta;
    logic [SPIN_CNT_W-1:0] r_spin_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta       <= BETA_RESET;
            r_spin_count <= SPIN_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BETA:       r_beta       <= i_cfg_data;
                CFG_SPIN_COUNT: r_spin_count <= i_cfg_data[SPIN_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [NW-1:0] n_eff;
    assign n_eff = (32'(r_spin_count) >= MAX_SPINS) ? NW'(MAX_SPINS) : NW'(r_spin_count);

    // latched request
    t_action                 r_action;
    logic [INDEX_W-1:0]      r_row, r_col, r_idx;
    logic [COUPLING_W-1:0]   r_coup;
    logic                    r_up;
    logic [RANDOM_W-1:0]     r_rnd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= t_action'(i_action);
            r_row    <= i_row;
            r_col    <= i_col;
            r_coup   <= i_coupling;
            r_idx    <= i_spin_index;
            r_up     <= i_spin_up;
            r_rnd    <= i_random_uniform;
        end
    end

    logic is_flip;
    assign is_flip = (r_action == ACT_FLIP);

    // walk control
    logic [NW:0]   r_cnt;
    logic [NW-1:0] r_rowi;
    logic          r_piv, r_pv, r_pskip;
    logic [NW-1:0] walk_j;
    logic [IW-1:0] j_idx, k_idx, row_idx;
    logic [NW:0]   walk_len;

    assign walk_j   = is_flip ? r_cnt[NW:1] : r_cnt[NW-1:0];
    assign j_idx    = IW'(walk_j);
    assign k_idx    = IW'(r_idx);
    assign row_idx  = IW'(r_rowi);
    assign walk_len = is_flip ? {n_eff, 1'b0} : {1'b0, n_eff};

    // stores
    logic                  c_we, s_we;
    logic [CAW-1:0]        c_waddr, c_raddr;
    logic [COUPLING_W-1:0] c_rdata;
    logic [IW-1:0]         s_waddr, s_raddr;
    logic                  s_wdata, s_rdata;
    logic                  row_ok, col_ok, idx_ok;
    logic                  accept_now;

    assign row_ok = 32'(r_row) < MAX_SPINS;
    assign col_ok = 32'(r_col) < MAX_SPINS;
    assign idx_ok = 32'(r_idx) < MAX_SPINS;

    assign c_we    = i_cmd.wr_store && (r_action == ACT_WR_COUPLING) && row_ok && col_ok;
    assign c_waddr = CAW'(IW'(r_row)) * CAW'(MAX_SPINS) + CAW'(IW'(r_col));

    always_comb begin
        if (!is_flip)      c_raddr = CAW'(row_idx) * CAW'(MAX_SPINS) + CAW'(j_idx);
        else if (!r_cnt[0]) c_raddr = CAW'(k_idx) * CAW'(MAX_SPINS) + CAW'(j_idx);
        else               c_raddr = CAW'(j_idx) * CAW'(MAX_SPINS) + CAW'(k_idx);
    end

    assign s_we    = (i_cmd.wr_store && (r_action == ACT_WR_SPIN) && idx_ok)
                   || (i_cmd.decide && accept_now);
    assign s_waddr = k_idx;
    assign s_wdata = i_cmd.decide ? ~r_piv : r_up;
    assign s_raddr = i_cmd.pivot_rd ? (is_flip ? k_idx : row_idx) : j_idx;

    imsf_ram #(.WIDTH(COUPLING_W), .DEPTH(MAX_SPINS * MAX_SPINS)) u_coupling_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (r_coup),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    imsf_ram #(.WIDTH(1), .DEPTH(MAX_SPINS)) u_spin_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // accumulate s_p * J * s_j one term a cycle
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] j_ext, term;

    assign j_ext = AW'(signed'(c_rdata));
    assign term  = (r_piv == s_rdata) ? j_ext : -j_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.walk_issue;
        end
        r_pskip <= is_flip && (j_idx == k_idx);
        if (i_cmd.load_item) begin
            r_acc  <= '0;
            r_rowi <= '0;
        end else begin
            if (r_pv && !r_pskip) r_acc <= r_acc + term;
            if (i_cmd.row_next)   r_rowi <= r_rowi + 1'b1;
        end
        if (i_cmd.pivot_rd)        r_cnt <= '0;
        else if (i_cmd.walk_issue) r_cnt <= r_cnt + 1'b1;
        if (i_cmd.pivot_lat)       r_piv <= s_rdata;
    end

    // acceptance test
    logic                       r_res_acc;
    logic signed [ENERGY_W-1:0] r_res_de, r_res_e;
    logic [XW-1:0]              r_x;
    logic [TIW-1:0]             r_ti;
    logic                       r_inr;
    logic [PW-1:0]              ti_prod;
    logic [16:0]                lim;

    assign ti_prod    = PW'(r_x[29:0]) * PW'(EXP_TABLE_DEPTH);
    assign lim        = r_inr ? EXP_TAB[r_ti] : 17'd0;
    assign accept_now = r_res_de[ENERGY_W-1] || ({1'b0, r_rnd} < lim);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_res_acc <= 1'b0;
            r_res_de  <= '0;
            r_res_e   <= '0;
        end else begin
            if (i_cmd.calc_de)     r_res_de  <= sat32({r_acc, 1'b0});
            if (i_cmd.decide)      r_res_acc <= accept_now;
            if (i_cmd.calc_energy) r_res_e   <= sat32(-(AW+1)'(r_acc));
        end
        if (i_cmd.calc_mul) r_x <= XW'(r_res_de[ENERGY_W-2:0]) * XW'(r_beta);
        if (i_cmd.calc_idx) begin
            r_inr <= (r_x[XW-1:30] == '0);
            r_ti  <= ti_prod[PW-2:30];
        end
    end

    // output register
    logic                       r_o_acc;
    logic signed [ENERGY_W-1:0] r_o_de, r_o_e;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_acc <= r_res_acc;
            r_o_de  <= r_res_de;
            r_o_e   <= r_res_e;
        end
    end

    assign o_accepted     = r_o_acc;
    assign o_delta_energy = r_o_de;
    assign o_energy       = r_o_e;

    assign o_sts.action    = r_action;
    assign o_sts.flip_ok   = 32'(r_idx) < 32'(n_eff);
    assign o_sts.n_zero    = (n_eff == '0);
    assign o_sts.walk_last = ((r_cnt + 1'b1) == walk_len);
    assign o_sts.row_last  = ((r_rowi + 1'b1) == n_eff);

endmodule

>>> rtl/core/ising_metropolis_spin_flip.sv
// Flips and energy reports walk the coupling store; N is the number of spins in use.
// A flip reads row k and column k through the single coupling read port, one entry a cycle.
// An energy report walks all N*N couplings row by row.
// One request is in flight at a time; the next is taken while the result waits to be collected.
// Reset (synchronous, active low) clears the sequencer and output valid, sets beta 1.0 and N 64.
// Spin and coupling stores are not cleared; the user must write entries before they are read (not enforced).
module ising_metropolis_spin_flip #(
    parameter int MAX_SPINS       = 64,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [imsf_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [imsf_pkg::BETA_W-1:0]            i_cfg_data,
    // request channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [imsf_pkg::ACTION_W-1:0]          i_action,
    input  logic [imsf_pkg::INDEX_W-1:0]           i_row,
    input  logic [imsf_pkg::INDEX_W-1:0]           i_col,
    input  logic signed [imsf_pkg::COUPLING_W-1:0] i_coupling,
    input  logic [imsf_pkg::INDEX_W-1:0]           i_spin_index,
    input  logic                                   i_spin_up,
    input  logic [imsf_pkg::RANDOM_W-1:0]          i_random_uniform,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_accepted,
    output logic signed [imsf_pkg::ENERGY_W-1:0]   o_delta_energy,
    output logic signed [imsf_pkg::ENERGY_W-1:0]   o_energy
);
    import imsf_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: owns request acceptance and the result valid flag
    imsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: config registers, stores, accumulator, exp table, result register
    imsf_datapath #(
        .MAX_SPINS       (MAX_SPINS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_coupling       (i_coupling),
        .i_spin_index     (i_spin_index),
        .i_spin_up        (i_spin_up),
        .i_random_uniform (i_random_uniform),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_accepted       (o_accepted),
        .o_delta_energy   (o_delta_energy),
        .o_energy         (o_energy)
    );

endmodule
